// ----- src/wrs_pkg.sv -----
`default_nettype none

package wrs_pkg;

  // Fixed field widths
  localparam int TS_W       = 64;
  localparam int RATE_W     = 52;
  localparam int SMOOTH_W   = 32;
  localparam int BACKLOG_W  = 16;
  localparam int WLEN_W     = 40;
  localparam int SCALE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // Default sizing of the stored window state
  localparam int COUNT_BITS_DEF = 32;
  localparam int TIME_BITS_DEF  = 64;

  // Register reset values
  localparam logic [WLEN_W-1:0]    WLEN_RST   = 40'd1000000000;
  localparam logic [BACKLOG_W-1:0] BLIMIT_RST = 16'd5000;
  localparam logic [SCALE_W-1:0]   SCALE_RST  = 20'd1000000;

  // (old*900 + count*100)/1000 reduces to (old*9 + count)/10
  localparam int SMOOTH_DIVISOR = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE    = 2'd2;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic commit;
  } wrs_cmd_t;

  typedef struct packed {
    logic close;
    logic elapsed_zero;
    logic div_last;
  } wrs_status_t;

endpackage

`default_nettype wire

// ----- src/windowed_rate_shaper.sv -----
// Flow: an item is loaded and evaluated, multiplied in two halves, divided bit-serially and
//   committed; a window close skips the divider, and zero elapsed time goes straight to finish.
// Throughput: one item in flight, next item taken once the result is committed and the control
//   is idle; the bit-serial divider (one quotient bit per cycle) sets the rate unless the output stalls.
// Reset: synchronous, active low; clears window state and restores register defaults.
`default_nettype none

module windowed_rate_shaper #(
  parameter int COUNT_BITS = wrs_pkg::COUNT_BITS_DEF,
  parameter int TIME_BITS  = wrs_pkg::TIME_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [wrs_pkg::TS_W-1:0]        in_timestamp_ns,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_drop,
  output logic [wrs_pkg::RATE_W-1:0]      out_current_rate,
  output logic [wrs_pkg::BACKLOG_W-1:0]   out_backlog_out,
  output logic [wrs_pkg::SMOOTH_W-1:0]    out_smoothed_out,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [wrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [wrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wrs_pkg::*;

  wrs_cmd_t    cmd;
  wrs_status_t status;

  assign cfg_ready = 1'b1;

  wrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wrs_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_timestamp_ns  (in_timestamp_ns),
    .cmd              (cmd),
    .status           (status),
    .out_drop         (out_drop),
    .out_current_rate (out_current_rate),
    .out_backlog_out  (out_backlog_out),
    .out_smoothed_out (out_smoothed_out)
  );

endmodule

`default_nettype wire

// ----- src/wrs_ctrl.sv -----
`default_nettype none

module wrs_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wrs_pkg::wrs_status_t status,
  output wrs_pkg::wrs_cmd_t    cmd
);
  import wrs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EVAL   = 6'b000010,
    ST_MUL_LO = 6'b000100,
    ST_MUL_HI = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.close) begin
          state_nxt = ST_MUL_LO;
        end else if (status.elapsed_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        // a closing window is done once the divide by ten lands
        if (status.close) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EVAL))
    else $error("accepted item did not enter evaluation");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && status.div_last) |=> (state_r == ST_FINISH))
    else $error("divider end not followed by finish");

endmodule

`default_nettype wire

// ----- src/wrs_datapath.sv -----
`default_nettype none

module wrs_datapath #(
  parameter int COUNT_BITS = wrs_pkg::COUNT_BITS_DEF,
  parameter int TIME_BITS  = wrs_pkg::TIME_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [wrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [wrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [wrs_pkg::TS_W-1:0]           in_timestamp_ns,
  input  wrs_pkg::wrs_cmd_t                  cmd,
  output wrs_pkg::wrs_status_t               status,
  output logic                               out_drop,
  output logic [wrs_pkg::RATE_W-1:0]         out_current_rate,
  output logic [wrs_pkg::BACKLOG_W-1:0]      out_backlog_out,
  output logic [wrs_pkg::SMOOTH_W-1:0]       out_smoothed_out
);
  import wrs_pkg::*;

  localparam int LO_W    = COUNT_BITS / 2;
  localparam int HI_W    = COUNT_BITS - LO_W;
  localparam int MP_W    = HI_W + SCALE_W;
  localparam int PROD_W  = COUNT_BITS + SCALE_W;
  localparam int SUM_W   = ((COUNT_BITS > SMOOTH_W + 4) ? COUNT_BITS : SMOOTH_W + 4) + 1;
  localparam int NUM_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int CMP_W   = (TIME_BITS > WLEN_W) ? TIME_BITS : WLEN_W;
  localparam int STEP_W  = $clog2(NUM_W + 1);
  localparam int QX_W    = NUM_W + RATE_W;

  // divide by ten in two halves: high part first, then remainder joined to the low part
  localparam int SPLIT_W = 18;
  localparam int D10_W   = SPLIT_W + 4;
  localparam int D10_SH  = D10_W + 4;
  localparam logic [D10_W:0] D10_RECIP =
    (D10_W + 1)'(((1 << D10_SH) + SMOOTH_DIVISOR - 1) / SMOOTH_DIVISOR);
  // sums at or above this give a smoothed value past 32 bits
  localparam logic [SUM_W-1:0] SMOOTH_CAP_SUM = SUM_W'(SMOOTH_DIVISOR) << SMOOTH_W;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_RATE   = 2'd1,
    MODE_SMOOTH = 2'd2
  } mode_t;

  // configuration and window state
  logic [WLEN_W-1:0]     wlen_r;
  logic [BACKLOG_W-1:0]  blimit_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [TIME_BITS-1:0]  start_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SMOOTH_W-1:0]   smooth_r;
  logic [BACKLOG_W-1:0]  backlog_r;
  mode_t                 mode_r;
  logic [STEP_W-1:0]     step_r;

  // per-item working registers
  logic [TIME_BITS-1:0]  now_r;
  logic [TIME_BITS-1:0]  elapsed_r;
  logic [MP_W-1:0]       plo_r;
  logic [NUM_W-1:0]      num_r;
  logic [TIME_BITS-1:0]  rem_r;
  logic [TIME_BITS-1:0]  dvsr_r;
  logic [SPLIT_W-1:0]    shi_r;
  logic [3:0]            srem_r;

  // result registers
  logic                  drop_r;
  logic [RATE_W-1:0]     rate_r;
  logic [BACKLOG_W-1:0]  backlog_out_r;
  logic [SMOOTH_W-1:0]   smooth_out_r;

  logic [TIME_BITS-1:0]  now_in;
  logic [TIME_BITS-1:0]  elapsed_in;
  logic                  close;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SUM_W-1:0]      smooth_sum;
  logic [HI_W-1:0]       mul_a;
  logic [MP_W-1:0]       mul_p;
  logic [PROD_W-1:0]     prod_full;
  logic [D10_W-1:0]      d10_in;
  logic [2*D10_W:0]      d10_prod;
  logic [SPLIT_W-1:0]    d10_q;
  logic [3:0]            d10_rem;
  logic                  smooth_cap;
  logic [TIME_BITS:0]    rem_sh;
  logic                  rem_ge;
  logic [TIME_BITS:0]    rem_sub;
  logic [TIME_BITS-1:0]  rem_nxt;
  logic [QX_W-1:0]       q_ext;
  logic [RATE_W-1:0]     rate_div;
  logic [SMOOTH_W-1:0]   smooth_div;
  logic [RATE_W-1:0]     rate_fin;
  logic [SMOOTH_W-1:0]   smooth_fin;
  logic                  over;
  logic                  drop_fin;
  logic [BACKLOG_W-1:0]  backlog_fin;

  assign now_in     = in_timestamp_ns[TIME_BITS-1:0];
  assign elapsed_in = now_in - start_r;

  assign close               = CMP_W'(elapsed_r) >= CMP_W'(wlen_r);
  assign status.close        = close;
  assign status.elapsed_zero = (elapsed_r == '0);
  assign status.div_last     = (step_r == STEP_W'(1));

  assign count_inc  = (count_r == '1) ? count_r : count_r + 1'b1;
  assign smooth_sum = SUM_W'({smooth_r, 3'b000}) + SUM_W'(smooth_r) + SUM_W'(count_r);

  // one shared multiplier, count taken in two halves
  assign mul_a     = cmd.mul_hi ? count_r[COUNT_BITS-1:LO_W] : HI_W'(count_r[LO_W-1:0]);
  assign mul_p     = MP_W'(mul_a) * MP_W'(scale_r);
  assign prod_full = PROD_W'(plo_r) + (PROD_W'(mul_p) << LO_W);

  // reciprocal divide by ten of the smoothing sum held in num_r
  assign d10_in     = cmd.mul_hi ? {srem_r, num_r[SPLIT_W-1:0]}
                                 : D10_W'(num_r[2*SPLIT_W-1:SPLIT_W]);
  assign d10_prod   = (2*D10_W+1)'(d10_in) * (2*D10_W+1)'(D10_RECIP);
  assign d10_q      = d10_prod[D10_SH +: SPLIT_W];
  assign d10_rem    = d10_in[3:0] - {d10_q[0], 3'b000} - {d10_q[2:0], 1'b0};
  assign smooth_cap = num_r[SUM_W-1:0] >= SMOOTH_CAP_SUM;

  // restoring divider, one quotient bit per cycle shifted into num_r
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvsr_r};
  assign rem_sub = rem_sh - {1'b0, dvsr_r};
  assign rem_nxt = rem_ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];

  assign q_ext      = QX_W'(num_r);
  assign rate_div   = (|q_ext[QX_W-1:RATE_W]) ? '1 : q_ext[RATE_W-1:0];
  assign smooth_div = (|num_r[NUM_W-1:SMOOTH_W]) ? '1 : num_r[SMOOTH_W-1:0];
  assign rate_fin   = (mode_r == MODE_RATE) ? rate_div : '0;
  assign smooth_fin = (mode_r == MODE_SMOOTH) ? smooth_div : smooth_r;
  assign over       = rate_fin > RATE_W'(smooth_fin);

  always_comb begin
    drop_fin    = 1'b0;
    backlog_fin = backlog_r;
    priority if (over && (backlog_r >= blimit_r)) begin
      drop_fin = 1'b1;
    end else if (over) begin
      backlog_fin = backlog_r + 1'b1;
    end else if (backlog_r != '0) begin
      backlog_fin = backlog_r - 1'b1;
    end else begin
      backlog_fin = backlog_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_RST;
      blimit_r  <= BLIMIT_RST;
      scale_r   <= SCALE_RST;
      start_r   <= '0;
      count_r   <= '0;
      smooth_r  <= '0;
      backlog_r <= '0;
      mode_r    <= MODE_NONE;
      step_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN:    wlen_r   <= cfg_data[WLEN_W-1:0];
          REG_BACKLOG_LIMIT: blimit_r <= cfg_data[BACKLOG_W-1:0];
          REG_RATE_SCALE:    scale_r  <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (close) begin
          // restart the window; this item is its first
          start_r <= now_r;
          count_r <= COUNT_BITS'(1);
          mode_r  <= MODE_SMOOTH;
        end else begin
          count_r <= count_inc;
          mode_r  <= status.elapsed_zero ? MODE_NONE : MODE_RATE;
        end
      end
      if (cmd.mul_hi) begin
        step_r <= STEP_W'(NUM_W);
      end
      if (cmd.div_step) begin
        step_r <= step_r - 1'b1;
      end
      if (cmd.commit) begin
        smooth_r  <= smooth_fin;
        backlog_r <= backlog_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= now_in;
      elapsed_r <= elapsed_in;
    end
    if (cmd.eval && close) begin
      num_r <= NUM_W'(smooth_sum);
    end
    if (cmd.mul_lo) begin
      plo_r  <= mul_p;
      shi_r  <= d10_q;
      srem_r <= d10_rem;
    end
    if (cmd.mul_hi) begin
      if (mode_r == MODE_SMOOTH) begin
        num_r <= smooth_cap ? NUM_W'({SMOOTH_W{1'b1}}) : NUM_W'({shi_r, d10_q});
      end else begin
        num_r  <= NUM_W'(prod_full);
        dvsr_r <= elapsed_r;
        rem_r  <= '0;
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[NUM_W-2:0], rem_ge};
    end
    if (cmd.commit) begin
      drop_r        <= drop_fin;
      rate_r        <= rate_fin;
      backlog_out_r <= backlog_fin;
      smooth_out_r  <= smooth_fin;
    end
  end

  assign out_drop         = drop_r;
  assign out_current_rate = rate_r;
  assign out_backlog_out  = backlog_out_r;
  assign out_smoothed_out = smooth_out_r;

  a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && close) |=> (count_r == COUNT_BITS'(1) && mode_r == MODE_SMOOTH))
    else $error("window close did not restart the count");

  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (step_r != '0))
    else $error("divider stepped past its last bit");

  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && mode_r != MODE_RATE) |=> (rate_r == '0))
    else $error("nonzero rate without a rate division");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import wrs_pkg::*;

  localparam int          SETTLE_CYCLES = 64;
  localparam int          STALL_LIMIT   = 4000;
  localparam logic [127:0] RATE_CAP     = (128'd1 << RATE_W) - 1;

  typedef struct packed {
    logic                 drop;
    logic [RATE_W-1:0]    rate;
    logic [BACKLOG_W-1:0] backlog;
    logic [SMOOTH_W-1:0]  smoothed;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TS_W-1:0]       in_timestamp_ns = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_drop;
  logic [RATE_W-1:0]     out_current_rate;
  logic [BACKLOG_W-1:0]  out_backlog_out;
  logic [SMOOTH_W-1:0]   out_smoothed_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // policer copy: registers and window state
  logic [WLEN_W-1:0]    win_len     = WLEN_RST;
  logic [BACKLOG_W-1:0] backlog_cap = BLIMIT_RST;
  logic [SCALE_W-1:0]   scale_mul   = SCALE_RST;
  logic [63:0]          win_start   = '0;
  logic [31:0]          win_count   = '0;
  logic [SMOOTH_W-1:0]  smooth_lvl  = '0;
  logic [BACKLOG_W-1:0] backlog_lvl = '0;

  logic [TS_W-1:0] arrivals[$];
  verdict_t        verdict_q[$];
  logic            in_taken = 1'b0;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_stall_pct = 0;
  logic [63:0]     gen_time = '0;
  logic [WLEN_W-1:0] cur_wlen = WLEN_RST;
  int              cfg_writes = 0;
  int              mismatches = 0;
  int              packets_in = 0;
  int              verdicts_seen = 0;
  int              drops_seen = 0;
  int              windows_opened = 0;
  int              settings_used = 1;
  int              quiet_cycles = 0;

  windowed_rate_shaper u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_timestamp_ns  (in_timestamp_ns),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drop         (out_drop),
    .out_current_rate (out_current_rate),
    .out_backlog_out  (out_backlog_out),
    .out_smoothed_out (out_smoothed_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Close the window if due, count the packet, then judge its rate.
  function automatic verdict_t police_packet(input logic [63:0] ts);
    logic [63:0]  elapsed;
    logic [63:0]  blended;
    logic [127:0] quo;
    verdict_t     v;
    v = '0;
    elapsed = ts - win_start;
    if (elapsed >= {24'd0, win_len}) begin
      blended = (64'(smooth_lvl) * 64'd900 + 64'(win_count) * 64'd100) / 64'd1000;
      smooth_lvl = (blended > 64'hFFFF_FFFF) ? '1 : blended[SMOOTH_W-1:0];
      win_start = ts;
      win_count = '0;
      elapsed = '0;
      windows_opened++;
    end
    if (win_count != '1) win_count++;
    if (elapsed != 0) begin
      quo = (128'(win_count) * 128'(scale_mul)) / 128'(elapsed);
      v.rate = (quo > RATE_CAP) ? RATE_CAP[RATE_W-1:0] : quo[RATE_W-1:0];
    end
    if (64'(v.rate) > 64'(smooth_lvl)) begin
      if (backlog_lvl >= backlog_cap) v.drop = 1'b1;
      else backlog_lvl++;
    end else if (backlog_lvl != 0) begin
      backlog_lvl--;
    end
    v.backlog = backlog_lvl;
    v.smoothed = smooth_lvl;
    return v;
  endfunction

  // item and register acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      verdict_q.push_back(police_packet(in_timestamp_ns));
      packets_in++;
      in_taken = 1'b1;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LEN:    win_len = cfg_data[WLEN_W-1:0];
        REG_BACKLOG_LIMIT: backlog_cap = cfg_data[BACKLOG_W-1:0];
        REG_RATE_SCALE:    scale_mul = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
      cfg_writes++;
    end
  end

  // driver: advance only once the current item is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (arrivals.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_timestamp_ns <= arrivals.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (out_drop) drops_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict: drop=%0d rate=%0d backlog=%0d smoothed=%0d",
                   out_drop, out_current_rate, out_backlog_out, out_smoothed_out);
      end else begin
        want = verdict_q.pop_front();
        if (out_drop !== want.drop || out_current_rate !== want.rate ||
            out_backlog_out !== want.backlog || out_smoothed_out !== want.smoothed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: exp drop=%0d rate=%0d backlog=%0d smoothed=%0d, got %0d %0d %0d %0d",
                     verdicts_seen, want.drop, want.rate, want.backlog, want.smoothed,
                     out_drop, out_current_rate, out_backlog_out, out_smoothed_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d verdicts outstanding",
               quiet_cycles, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [WLEN_W-1:0] wlen, input logic [BACKLOG_W-1:0] cap,
                          input logic [SCALE_W-1:0] scale);
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(wlen));
    write_reg(REG_BACKLOG_LIMIT, CFG_DATA_W'(cap));
    write_reg(REG_RATE_SCALE, CFG_DATA_W'(scale));
    cur_wlen = wlen;
    settings_used++;
  endtask

  task automatic push_after(input logic [63:0] step);
    gen_time = gen_time + step;
    arrivals.push_back(gen_time);
  endtask

  // mostly ordered arrivals paced against the window, with some stray timestamps
  task automatic queue_traffic(input int n, input int unsigned tx, input int unsigned rx);
    logic [63:0] span;
    logic [63:0] ts;
    int unsigned pick;
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    span = (cur_wlen > 40'd1000000) ? 64'd1000000 : 64'(cur_wlen);
    if (span == 0) span = 64'd1;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        ts = {$urandom, $urandom};
        arrivals.push_back(ts);
        if (pick < 6) gen_time = ts;
      end else if (pick < 22) begin
        push_after(64'd0);
      end else if (pick < 72) begin
        push_after(64'($urandom) % (span / 8 + 1) + 64'd1);
      end else if (pick < 94) begin
        push_after(span / 2 + 64'($urandom) % (2 * span));
      end else begin
        push_after(64'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (arrivals.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero elapsed, window boundary, wraparound, bit patterns
    arrivals.push_back(64'd0);
    arrivals.push_back(64'd0);
    arrivals.push_back(64'd1);
    arrivals.push_back(64'd2);
    arrivals.push_back(64'd999_999_999);
    arrivals.push_back(64'd1_000_000_000);
    arrivals.push_back(64'd1_000_000_001);
    arrivals.push_back('1);
    arrivals.push_back(64'd0);
    arrivals.push_back(64'h5555_5555_5555_5555);
    arrivals.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    gen_time = 64'hAAAA_AAAA_AAAA_AAAA;
    drain();

    // zero scale keeps the rate at zero
    set_regs('1, 16'd0, 20'd0);
    push_after(64'd1);
    push_after(64'd2);
    drain();
    // zero window length opens a window on every packet
    set_regs('0, 16'd0, '1);
    push_after(64'd0);
    push_after(64'd5);
    drain();
    // zero backlog limit drops every over-rate packet
    set_regs(40'd1000, 16'd0, '1);
    push_after(64'd1000);
    push_after(64'd1);
    push_after(64'd1);
    drain();
    set_regs(40'd1000, '1, 20'd1);
    push_after(64'd1);
    push_after(64'd3);
    drain();

    set_regs(40'd2000, 16'd3, 20'd1000);
    queue_traffic(75, 0, 0);
    drain();
    set_regs(40'd1, 16'd0, '1);
    queue_traffic(75, 52, 0);
    drain();
    set_regs(40'd500, '1, 20'd1);
    queue_traffic(75, 0, 52);
    drain();
    set_regs('1, 16'd8, 20'd50000);
    queue_traffic(75, 26, 26);
    drain();
    set_regs(40'd10000, 16'd2, 20'd4000);
    queue_traffic(75, 0, 0);
    drain();
    set_regs(40'd300, 16'd20, 20'd700);
    queue_traffic(75, 26, 26);
    drain();

    $display("%0d packets checked over %0d register settings", verdicts_seen, settings_used);
    $display("%0d dropped, %0d windows opened", drops_seen, windows_opened);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d verdicts missing", mismatches, verdict_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wrs_pkg.sv
src/wrs_ctrl.sv
src/wrs_datapath.sv
src/windowed_rate_shaper.sv
sim/testbench.sv
